FILE: rtl/wstd_pkg.sv
// ----------------------------------------------------------------------------
// wstd_pkg
// shared types and constants of the work stealing task dispatcher
// ----------------------------------------------------------------------------
package wstd_pkg;

  // field widths of the stream transactions
  localparam int unsigned CmdW     = 2;
  localparam int unsigned WorkerW  = 3;
  localparam int unsigned WordW    = 64;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CfgW     = 4;

  // packed widths, padded to whole bytes
  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 152;

  localparam logic [CountW-1:0] PendingMax   = 11'd2047;
  localparam logic [CfgW-1:0]   WorkerCntRst = 4'd8;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_FETCH    = 2'd1,
    CMD_COMPLETE = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NO_TASK   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NULL      = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_e;

endpackage

FILE: rtl/work_stealing_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_unit
// per-worker circular task queues with enqueue, fetch with round-robin
// stealing from the other active queues, and an outstanding task count
// ----------------------------------------------------------------------------
// result: the result of a transaction is registered and presented in the cycle after it is accepted
// throughput: one transaction per cycle while the result side keeps taking results;
//   the single output register, which also holds the store read data, sets this
// reset: queue pointers and the outstanding count clear at once, worker_count
//   returns to 8; the task stores are not cleared and need no clearing pass
module work_stealing_task_dispatcher_unit
  import wstd_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // command [1:0], worker [4:2], task_handler [68:5], task_argument [132:69]
  input  logic [InDataW-1:0]  s_axis_tdata,

  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status [2:0], handler_out [66:3], argument_out [130:67],
  // source_queue [133:131], outstanding [144:134], all_done [145]
  output logic [OutDataW-1:0] m_axis_tdata,

  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(NUM_QUEUES + 1);
  localparam int unsigned MemDepth = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(MemDepth);
  localparam logic [PW-1:0] PtrLast = PW'(QUEUE_DEPTH - 1);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] worker_count_q;
  logic            cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-CfgW){1'b0}}, worker_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WorkerCntRst;
    end else if (cfg_we) begin
      worker_count_q <= pwdata[CfgW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // request fields
  // --------------------------------------------------------------------------
  cmd_e               cmd;
  logic [WorkerW-1:0] worker;
  logic [WordW-1:0]   task_handler;
  logic [WordW-1:0]   task_argument;

  assign cmd           = cmd_e'(s_axis_tdata[1:0]);
  assign worker        = s_axis_tdata[4:2];
  assign task_handler  = s_axis_tdata[68:5];
  assign task_argument = s_axis_tdata[132:69];

  // --------------------------------------------------------------------------
  // queue state
  // --------------------------------------------------------------------------
  logic [PW-1:0]     head_q [NUM_QUEUES];
  logic [PW-1:0]     tail_q [NUM_QUEUES];
  logic [CountW-1:0] pending_q;

  // result register, store read data held beside it
  logic              valid_q;
  status_e           status_q;
  logic [WorkerW-1:0] src_q;
  logic              done_q;
  logic              fetch_ok_q;
  logic [WordW-1:0]  hrd_q;
  logic [WordW-1:0]  ard_q;

  logic accept;
  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // lowest set bit of a queue mask
  function automatic logic [QW-1:0] lowest_set(input logic [NUM_QUEUES-1:0] v);
    logic [QW-1:0] r;
    r = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (v[i]) r = QW'(i);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // decision logic
  // --------------------------------------------------------------------------
  logic [NW-1:0]         active_n;
  logic                  worker_active;
  logic [QW-1:0]         worker_q;
  logic [NUM_QUEUES-1:0] nonempty;
  logic [NUM_QUEUES-1:0] from_worker_up;
  logic [QW-1:0]         pick;
  logic [QW-1:0]         qsel;
  logic [PW-1:0]         head_sel;
  logic [PW-1:0]         tail_sel;
  logic [PW-1:0]         head_adv;
  logic [PW-1:0]         tail_adv;
  logic                  enq_ok;
  logic                  fetch_ok;
  status_e               status_d;
  logic [WorkerW-1:0]    src_d;
  logic                  done_d;
  logic [CountW-1:0]     pending_d;
  logic [AW-1:0]         mem_addr;

  always_comb begin
    // active queue count, clamped to 1..NUM_QUEUES
    if (worker_count_q == '0) begin
      active_n = NW'(1);
    end else if (32'(worker_count_q) > NUM_QUEUES) begin
      active_n = NW'(NUM_QUEUES);
    end else begin
      active_n = NW'(worker_count_q);
    end
    worker_active = 32'(worker) < 32'(active_n);
    worker_q      = QW'(worker);

    // rotating pick: own queue first, then upward, then wrap to queue zero
    for (int i = 0; i < NUM_QUEUES; i++) begin
      nonempty[i]       = (head_q[i] != tail_q[i]) && (32'(i) < 32'(active_n));
      from_worker_up[i] = 32'(i) >= 32'(worker);
    end
    if (|(nonempty & from_worker_up)) begin
      pick = lowest_set(nonempty & from_worker_up);
    end else begin
      pick = lowest_set(nonempty);
    end

    qsel     = (cmd == CMD_FETCH) ? pick : worker_q;
    head_sel = head_q[qsel];
    tail_sel = tail_q[qsel];
    head_adv = (head_sel == PtrLast) ? '0 : head_sel + PW'(1);
    tail_adv = (tail_sel == PtrLast) ? '0 : tail_sel + PW'(1);

    enq_ok    = 1'b0;
    fetch_ok  = 1'b0;
    status_d  = ST_NO_TASK;
    src_d     = worker;
    done_d    = 1'b0;
    pending_d = pending_q;

    case (cmd)
      CMD_ENQUEUE: begin
        if (task_handler == '0) begin
          status_d = ST_NULL;
        end else if (!worker_active || pending_q >= PendingMax || head_adv == tail_sel) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_OK;
          enq_ok    = 1'b1;
          pending_d = pending_q + CountW'(1);
        end
      end
      CMD_FETCH: begin
        if (worker_active && |nonempty) begin
          status_d = ST_OK;
          fetch_ok = 1'b1;
          src_d    = WorkerW'(pick);
        end
      end
      CMD_COMPLETE: begin
        if (pending_q == '0) begin
          status_d = ST_UNDERFLOW;
        end else begin
          status_d  = ST_OK;
          pending_d = pending_q - CountW'(1);
          done_d    = (pending_d == '0);
        end
      end
      default: begin
        status_d = ST_NO_TASK;
      end
    endcase

    // enqueue writes at the head slot, fetch reads at the tail slot
    mem_addr = AW'(32'(qsel) * QUEUE_DEPTH) + AW'(enq_ok ? head_sel : tail_sel);
  end

  // --------------------------------------------------------------------------
  // task stores, one access per cycle
  // --------------------------------------------------------------------------
  logic [WordW-1:0] handler_mem  [MemDepth];
  logic [WordW-1:0] argument_mem [MemDepth];
  logic             mem_we;
  logic             mem_re;

  assign mem_we = accept && enq_ok;
  assign mem_re = accept && fetch_ok;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      handler_mem[mem_addr]  <= task_handler;
      argument_mem[mem_addr] <= task_argument;
    end
    if (mem_re) begin
      hrd_q <= handler_mem[mem_addr];
      ard_q <= argument_mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // pointer, count and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
      pending_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (accept) begin
        pending_q <= pending_d;
        if (enq_ok) begin
          head_q[qsel] <= head_adv;
        end
        if (fetch_ok) begin
          tail_q[qsel] <= tail_adv;
        end
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      src_q      <= src_d;
      done_q     <= done_d;
      fetch_ok_q <= fetch_ok;
    end
  end

  // outstanding is the count itself: it only moves when the next result loads
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {
    6'd0,
    done_q,
    pending_q,
    src_q,
    fetch_ok_q ? ard_q : {WordW{1'b0}},
    fetch_ok_q ? hrd_q : {WordW{1'b0}},
    status_q
  };

`ifndef SYNTHESIS
  // a finished count is reported only with a zero count
  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q |-> pending_q == '0)
    else $error("all_done with nonzero outstanding count");

  // store is single ported: never a write and a read together
  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store written and read in one cycle");

  // accepted enqueue raises the count by one
  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> pending_q == $past(pending_q) + CountW'(1))
    else $error("enqueue did not raise the count");

  // a fetched task only ever comes with status ok
  a_fetch_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && fetch_ok_q |-> status_q == ST_OK)
    else $error("fetched task without ok status");
`endif

endmodule

FILE: sim/work_stealing_task_dispatcher_unit_test.sv
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_unit_test
// self-checking bench for the work stealing task dispatcher: a scoreboard
// keeps its own copy of the per-worker queues and the outstanding count,
// predicts the result of every accepted request, and compares each result
// field by field; directed corner cases, a queue saturation run with steals
// from the full queue, and random traffic under several worker counts with
// random back-pressure
// ----------------------------------------------------------------------------
module work_stealing_task_dispatcher_unit_test;
  import wstd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_QUEUES    = 8;
  localparam int unsigned QUEUE_DEPTH   = 256;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned MaxReported   = 40;
  localparam int unsigned PhaseRequests = 166;

  // command 3 is not a real operation, the block answers with no task
  localparam logic [CmdW-1:0] CmdUnknown      = 2'd3;
  localparam logic [2:0]      AddrWorkerCount = 3'd0;

  // one predicted result transaction
  typedef struct {
    status_e             status;
    logic [WordW-1:0]    handler;
    logic [WordW-1:0]    argument;
    logic [WorkerW-1:0]  source;
    logic [CountW-1:0]   outstanding;
    logic                all_done;
  } dispatch_outcome_t;

  // --------------------------------------------------------------------------
  // scoreboard: shadow queues, outstanding count and the expected results
  // --------------------------------------------------------------------------
  class dispatch_scoreboard;
    logic [WordW-1:0]  task_handlers  [NUM_QUEUES*QUEUE_DEPTH];
    logic [WordW-1:0]  task_arguments [NUM_QUEUES*QUEUE_DEPTH];
    int unsigned       queue_head [NUM_QUEUES];
    int unsigned       queue_tail [NUM_QUEUES];
    int unsigned       tasks_outstanding;
    logic [CfgW-1:0]   worker_count_reg;
    dispatch_outcome_t awaited_outcomes[$];

    int unsigned mismatches, requests_seen, outcomes_checked;
    int unsigned stolen_fetches, empty_fetches, full_drops, limit_drops;
    int unsigned inactive_drops, null_handlers, underflows, done_flags;

    function new();
      foreach (queue_head[q]) begin
        queue_head[q] = 0;
        queue_tail[q] = 0;
      end
      tasks_outstanding = 0;
      worker_count_reg  = WorkerCntRst;
    endfunction

    function void set_worker_count(logic [CfgW-1:0] value);
      worker_count_reg = value;
    endfunction

    // register value is clamped to 1..NUM_QUEUES when used
    function int unsigned active_workers();
      if (worker_count_reg == '0) return 1;
      if (worker_count_reg > NUM_QUEUES) return NUM_QUEUES;
      return worker_count_reg;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
    endfunction

    function int unsigned queue_fill(int unsigned q);
      return (queue_head[q] + QUEUE_DEPTH - queue_tail[q]) % QUEUE_DEPTH;
    endfunction

    function int unsigned queued_total();
      int unsigned sum;
      sum = 0;
      for (int unsigned q = 0; q < NUM_QUEUES; q++) sum += queue_fill(q);
      return sum;
    endfunction

    function int unsigned outcomes_waiting();
      return awaited_outcomes.size();
    endfunction

    // work out the result of one accepted request and update the shadow state
    function void note_request(logic [CmdW-1:0] cmd, logic [WorkerW-1:0] worker,
                               logic [WordW-1:0] handler, logic [WordW-1:0] argument);
      dispatch_outcome_t o;
      int unsigned n, w, q, nx;
      n = active_workers();
      w = worker;
      o.status   = ST_NO_TASK;
      o.handler  = '0;
      o.argument = '0;
      o.source   = worker;
      o.all_done = 1'b0;
      requests_seen++;
      case (cmd)
        CMD_ENQUEUE: begin
          if (handler == '0) begin
            o.status = ST_NULL;
            null_handlers++;
          end else if (w >= n) begin
            o.status = ST_FULL;
            inactive_drops++;
          end else if (tasks_outstanding >= PendingMax) begin
            o.status = ST_FULL;
            limit_drops++;
          end else begin
            nx = next_slot(queue_head[w]);
            if (nx == queue_tail[w]) begin
              o.status = ST_FULL;
              full_drops++;
            end else begin
              task_handlers[w*QUEUE_DEPTH + queue_head[w]]  = handler;
              task_arguments[w*QUEUE_DEPTH + queue_head[w]] = argument;
              queue_head[w] = nx;
              tasks_outstanding++;
              o.status = ST_OK;
            end
          end
        end
        CMD_FETCH: begin
          // own queue first, then round robin over the active ones after it
          if (w < n) begin
            for (int unsigned i = 0; i < n; i++) begin
              q = (w + i) % n;
              if (queue_head[q] != queue_tail[q]) begin
                o.handler  = task_handlers[q*QUEUE_DEPTH + queue_tail[q]];
                o.argument = task_arguments[q*QUEUE_DEPTH + queue_tail[q]];
                queue_tail[q] = next_slot(queue_tail[q]);
                o.status = ST_OK;
                o.source = WorkerW'(q);
                if (i != 0) stolen_fetches++;
                break;
              end
            end
          end
          if (o.status != ST_OK) empty_fetches++;
        end
        CMD_COMPLETE: begin
          if (tasks_outstanding == 0) begin
            o.status = ST_UNDERFLOW;
            underflows++;
          end else begin
            tasks_outstanding--;
            o.status   = ST_OK;
            o.all_done = (tasks_outstanding == 0);
            if (o.all_done) done_flags++;
          end
        end
        default: ;
      endcase
      o.outstanding = CountW'(tasks_outstanding);
      awaited_outcomes.push_back(o);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MaxReported) $display("mismatch: %s", msg);
    endtask

    // compare one accepted result with the oldest expectation
    task check_outcome(logic [OutDataW-1:0] d);
      dispatch_outcome_t o;
      if (awaited_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  outcomes_checked));
      end else begin
        o = awaited_outcomes.pop_front();
        if (d[2:0] !== o.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    outcomes_checked, d[2:0], o.status));
        if (d[66:3] !== o.handler)
          report_mismatch($sformatf("result %0d handler %h, expected %h",
                                    outcomes_checked, d[66:3], o.handler));
        if (d[130:67] !== o.argument)
          report_mismatch($sformatf("result %0d argument %h, expected %h",
                                    outcomes_checked, d[130:67], o.argument));
        if (d[133:131] !== o.source)
          report_mismatch($sformatf("result %0d source queue %0d, expected %0d",
                                    outcomes_checked, d[133:131], o.source));
        if (d[144:134] !== o.outstanding)
          report_mismatch($sformatf("result %0d outstanding %0d, expected %0d",
                                    outcomes_checked, d[144:134], o.outstanding));
        if (d[145] !== o.all_done)
          report_mismatch($sformatf("result %0d all_done %b, expected %b",
                                    outcomes_checked, d[145], o.all_done));
      end
      outcomes_checked++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports
  // --------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // command [1:0], worker [4:2], task_handler [68:5], task_argument [132:69]
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // status [2:0], handler_out [66:3], argument_out [130:67],
  // source_queue [133:131], outstanding [144:134], all_done [145]
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [2:0]          paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;

  always #5 clk_i = ~clk_i;

  work_stealing_task_dispatcher_unit #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  dispatch_scoreboard sb;

  // sender burst bookkeeping, owned by the stimulus process
  int unsigned burst_left = 0;

  // long receiver hold-off: the stimulus bumps the request count, the
  // receiver notices the change and counts the hold down on its own
  int unsigned hold_trigger = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_done   = 0;

  // receiver stall pattern state, used only in the receiver process
  int unsigned rx_mode      = 0;
  int unsigned rx_mode_left = 0;

  int unsigned idle_cycles = 0;

  // --------------------------------------------------------------------------
  // result side: check every accepted result, then pick the next tready
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_outcome(m_axis_tdata);
    if (hold_trigger != hold_served) begin
      hold_served   <= hold_trigger;
      hold_left     <= HoldCycles;
      holds_done    <= holds_done + 1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      // stretches of always ready, mostly ready and mostly stalled
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(16, 96);
      end
      rx_mode_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // watchdog: too long without any transaction on any port ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  function automatic logic [WordW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WordW-1:0] task_word();
    logic [WordW-1:0] w;
    do w = random_word(); while (w == '0);
    return w;
  endfunction

  // bursts of random length separated by random gaps, some gaps empty
  task automatic pace_requests();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // offer one request and hold it until the block takes it
  task automatic send_request(logic [CmdW-1:0] cmd, logic [WorkerW-1:0] worker,
                              logic [WordW-1:0] handler, logic [WordW-1:0] argument);
    s_axis_tdata  <= InDataW'({argument, handler, worker, cmd});
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, worker, handler, argument);
    pace_requests();
  endtask

  // one register access: setup cycle, access cycle, then idle with psel low
  task automatic cfg_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= AddrWorkerCount;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // change worker_count only once the block has drained, then read it back
  task automatic set_worker_count(logic [CfgW-1:0] value);
    logic [31:0] rdata;
    s_axis_tvalid <= 1'b0;
    while (sb.outcomes_waiting() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_access(1'b1, 32'(value), rdata);
    sb.set_worker_count(value);
    cfg_access(1'b0, '0, rdata);
    if (rdata[CfgW-1:0] !== value)
      sb.report_mismatch($sformatf("worker_count reads %0d after writing %0d",
                                   rdata[CfgW-1:0], value));
  endtask

  // one random request; mostly active workers, some null handlers and noise
  task automatic random_request(int unsigned enqueue_pct);
    int unsigned roll, fetch_end, n;
    logic [WorkerW-1:0] w;
    logic [WordW-1:0] handler;
    n = sb.active_workers();
    roll = $urandom_range(0, 99);
    fetch_end = enqueue_pct + (97 - enqueue_pct) * 2 / 3;
    if ($urandom_range(0, 9) < 8) w = WorkerW'($urandom_range(0, n - 1));
    else w = WorkerW'($urandom_range(0, NUM_QUEUES - 1));
    handler = ($urandom_range(0, 19) == 0) ? '0 : random_word();
    if (roll < enqueue_pct) send_request(CMD_ENQUEUE, w, handler, random_word());
    else if (roll < fetch_end) send_request(CMD_FETCH, w, random_word(), random_word());
    else if (roll < 97) send_request(CMD_COMPLETE, w, random_word(), random_word());
    else send_request(CmdUnknown, w, random_word(), random_word());
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] rdata;
    logic [CfgW-1:0] phase_counts [7];
    int unsigned enqueue_pct;
    sb = new();
    phase_counts = '{4'd3, 4'd1, 4'd15, 4'd0, 4'd6, 4'd8, 4'd5};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // worker_count must come out of reset at its default
    cfg_access(1'b0, '0, rdata);
    if (rdata[CfgW-1:0] !== WorkerCntRst)
      sb.report_mismatch($sformatf("worker_count reads %0d after reset",
                                   rdata[CfgW-1:0]));

    // directed: empty fetch, underflow, unknown command, null handler
    send_request(CMD_FETCH, 3'd0, '0, '0);
    send_request(CMD_COMPLETE, 3'd0, '0, '0);
    send_request(CmdUnknown, 3'd7, '1, '1);
    send_request(CMD_ENQUEUE, 3'd3, '0, '1);
    // word extremes, own fetch and steals in round-robin order
    send_request(CMD_ENQUEUE, 3'd0, '1, '1);
    send_request(CMD_ENQUEUE, 3'd7, 64'h1, '0);
    send_request(CMD_ENQUEUE, 3'd2, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
    send_request(CMD_FETCH, 3'd0, '0, '0);
    send_request(CMD_FETCH, 3'd0, '0, '0);
    send_request(CMD_FETCH, 3'd5, '0, '0);
    send_request(CMD_FETCH, 3'd6, '0, '0);
    // completions down to zero raise all_done, one more underflows
    repeat (3) send_request(CMD_COMPLETE, 3'd4, '0, '0);
    send_request(CMD_COMPLETE, 3'd4, '0, '0);

    // two active workers: inactive enqueue and fetch, steal with wrap-around
    set_worker_count(4'd2);
    send_request(CMD_ENQUEUE, 3'd5, 64'hAAAA_AAAA_AAAA_AAAA, '1);
    send_request(CMD_FETCH, 3'd5, '0, '0);
    send_request(CMD_ENQUEUE, 3'd1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    send_request(CMD_FETCH, 3'd0, '0, '0);
    send_request(CMD_ENQUEUE, 3'd0, task_word(), random_word());
    send_request(CMD_FETCH, 3'd1, '0, '0);
    repeat (2) send_request(CMD_COMPLETE, 3'd1, '0, '0);

    // saturation: queue 0 filled until it refuses a task
    set_worker_count(4'd8);
    while (sb.queue_fill(0) < QUEUE_DEPTH - 1)
      send_request(CMD_ENQUEUE, 3'd0, task_word(), random_word());
    send_request(CMD_ENQUEUE, 3'd0, task_word(), random_word());
    // worker 5 steals from the full queue across the wrap, then room opens up
    repeat (8) send_request(CMD_FETCH, 3'd5, random_word(), random_word());
    send_request(CMD_ENQUEUE, 3'd0, task_word(), random_word());

    // random traffic under several worker counts, raw values outside 1..8 too
    foreach (phase_counts[p]) begin
      set_worker_count(phase_counts[p]);
      enqueue_pct = $urandom_range(30, 65);
      for (int unsigned i = 0; i < PhaseRequests; i++) begin
        // receiver holds off while requests keep coming, the block backs up
        if (p == 2 && i == 40) hold_trigger <= hold_trigger + 1;
        random_request(enqueue_pct);
      end
    end

    // drain, then give the block time for any stray result
    s_axis_tvalid <= 1'b0;
    while (sb.outcomes_waiting() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d requests, %0d results, %0d long hold(s), %0d steals",
             sb.requests_seen, sb.outcomes_checked, holds_done, sb.stolen_fetches);
    $display("empty %0d, full %0d, limit %0d, inactive %0d, null %0d, under %0d, done %0d",
             sb.empty_fetches, sb.full_drops, sb.limit_drops, sb.inactive_drops,
             sb.null_handlers, sb.underflows, sb.done_flags);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
